>>> rtl/tac_pkg.sv
package tac_pkg;

   // fraction bits of positions and curvature
   localparam int FRAC_BITS = 16;

   localparam int POS_W  = 32;
   localparam int HEAD_W = 16;
   localparam int DIFF_W = POS_W + 1;
   localparam int PROD_W = DIFF_W + HEAD_W;
   localparam int DOT_W  = PROD_W + 1;
   localparam int SQ1_W  = 2 * POS_W + 1;
   localparam int D2_W   = SQ1_W + 1;
   localparam int CM_W   = DOT_W - 1;

   // partial products of the squared cross term and of t2 * d2
   localparam int CM_LO_W = (CM_W + 1) / 2;
   localparam int CM_HI_W = CM_W - CM_LO_W;
   localparam int PPLL_W  = 2 * CM_LO_W;
   localparam int PPHL_W  = CM_LO_W + CM_HI_W;
   localparam int PPHH_W  = 2 * CM_HI_W;
   localparam int D2_C_W  = D2_W / 3;
   localparam int SQ_W    = 2 * CM_W;

   localparam int MD_W   = 16;
   localparam int TS_W   = 15;
   localparam int MDSQ_W = 2 * MD_W;
   localparam int T2_W   = 2 * TS_W;
   localparam int TPROD_W = T2_W + D2_C_W;

   localparam int CURV_W    = 32;
   localparam int QUO_W     = CURV_W - 1;
   localparam int DIV_SHIFT = 2 * FRAC_BITS - 13;
   localparam int NUM_W     = CM_W + DIV_SHIFT;

   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_ARC     = 2'd0;
   localparam logic [ST_W-1:0] ST_REACHED = 2'd1;
   localparam logic [ST_W-1:0] ST_BEHIND  = 2'd2;

   localparam logic signed [CURV_W-1:0] CURV_MAX = {1'b0, {(CURV_W-1){1'b1}}};
   localparam logic signed [CURV_W-1:0] CURV_MIN = {1'b1, {(CURV_W-1){1'b0}}};

   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = CSR_AW - 2;
   localparam logic [REG_IDX_W-1:0] REG_MIN_DISTANCE  = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_MIN_TURN_SINE = 1'b1;

   localparam logic [MD_W-1:0]   MIN_DISTANCE_RST  = 16'd7;
   localparam logic [TS_W-1:0]   MIN_TURN_SINE_RST = 15'd16;
   localparam logic [MDSQ_W-1:0] MD_SQ_RST =
      MDSQ_W'(MIN_DISTANCE_RST) * MDSQ_W'(MIN_DISTANCE_RST);
   localparam logic [T2_W-1:0]   T2_RST =
      T2_W'(MIN_TURN_SINE_RST) * T2_W'(MIN_TURN_SINE_RST);

   typedef struct packed {
      logic [MDSQ_W-1:0] md_sq;
      logic [T2_W-1:0]   t2;
   } tac_cfg_type;

   // one entry of the divider chain
   typedef struct packed {
      logic [D2_W-1:0]  rem;
      logic [D2_W-1:0]  den;
      logic [QUO_W-1:0] num_lo;
      logic [QUO_W-1:0] quo;
      logic [ST_W-1:0]  status;
      logic             zero;
      logic             neg;
      logic             ovf;
   } tac_div_type;

endpackage

>>> rtl/tac_if.sv
interface tac_req_if;
   import tac_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  start_x;
   logic signed [POS_W-1:0]  start_y;
   logic signed [HEAD_W-1:0] heading_x;
   logic signed [HEAD_W-1:0] heading_y;
   logic signed [POS_W-1:0]  goal_x;
   logic signed [POS_W-1:0]  goal_y;

   modport source (output valid, start_x, start_y, heading_x, heading_y, goal_x, goal_y,
                   input ready);
   modport sink (input valid, start_x, start_y, heading_x, heading_y, goal_x, goal_y,
                 output ready);
endinterface

interface tac_rsp_if;
   import tac_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ST_W-1:0]          status;
   logic signed [CURV_W-1:0] arc_curvature;

   modport source (output valid, status, arc_curvature, input ready);
   modport sink (input valid, status, arc_curvature, output ready);
endinterface

>>> rtl/tac_cfg.sv
module tac_cfg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tac_pkg::CSR_AW-1:0]  paddr,
   input  logic [tac_pkg::CSR_DW-1:0]  pwdata,
   output logic [tac_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output tac_pkg::tac_cfg_type        cfg
);
   import tac_pkg::*;

   logic                 wr;
   logic [REG_IDX_W-1:0] idx;
   logic [MD_W-1:0]      md_ff, md_in;
   logic [TS_W-1:0]      ts_ff, ts_in;
   logic [MDSQ_W-1:0]    md_sq_ff, md_sq_in;
   logic [T2_W-1:0]      t2_ff, t2_in;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[CSR_AW-1:2];

   // squares are kept alongside so the datapath compares against them directly
   always_comb begin
      md_in    = md_ff;
      ts_in    = ts_ff;
      md_sq_in = md_sq_ff;
      t2_in    = t2_ff;
      if (wr) begin
         unique case (idx)
            REG_MIN_DISTANCE: begin
               md_in    = pwdata[MD_W-1:0];
               md_sq_in = MDSQ_W'(pwdata[MD_W-1:0]) * MDSQ_W'(pwdata[MD_W-1:0]);
            end
            REG_MIN_TURN_SINE: begin
               ts_in = pwdata[TS_W-1:0];
               t2_in = T2_W'(pwdata[TS_W-1:0]) * T2_W'(pwdata[TS_W-1:0]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         md_ff    <= MIN_DISTANCE_RST;
         ts_ff    <= MIN_TURN_SINE_RST;
         md_sq_ff <= MD_SQ_RST;
         t2_ff    <= T2_RST;
      end else begin
         md_ff    <= md_in;
         ts_ff    <= ts_in;
         md_sq_ff <= md_sq_in;
         t2_ff    <= t2_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_MIN_DISTANCE:  prdata = {{(CSR_DW-MD_W){1'b0}}, md_ff};
         REG_MIN_TURN_SINE: prdata = {{(CSR_DW-TS_W){1'b0}}, ts_ff};
      endcase
   end

   assign cfg.md_sq = md_sq_ff;
   assign cfg.t2    = t2_ff;

endmodule

>>> rtl/tac_front.sv
module tac_front (
   input  logic                 clock,
   input  logic                 reset,
   input  tac_pkg::tac_cfg_type cfg,
   tac_req_if.sink              req_if,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tac_pkg::tac_div_type out_data
);
   import tac_pkg::*;

   localparam int NSTG = 7;

   logic [NSTG-1:0] v_ff, v_in;
   logic [NSTG:0]   adv;

   // stage 1: offset
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [HEAD_W-1:0] hx_ff, hy_ff;
   // stage 2: products
   logic signed [PROD_W-1:0] pxy_ff, pxy_in, pyx_ff, pyx_in;
   logic signed [PROD_W-1:0] pxx_ff, pxx_in, pyy_ff, pyy_in;
   logic signed [D2_W-1:0]   sqx_full, sqy_full;
   logic [SQ1_W-1:0]         sqx_ff, sqy_ff;
   // stage 3: cross, dot, squared distance
   logic signed [DOT_W-1:0]  cross_ff, cross_in, dot_ff, dot_in, cross_neg;
   logic [D2_W-1:0]          d2_3_ff, d2_3_in;
   // stage 4: magnitude and early status
   logic [CM_W-1:0]          cm4_ff, cm4_in;
   logic                     neg4_ff;
   logic [ST_W-1:0]          st4_ff, st4_in;
   logic [D2_W-1:0]          d2_4_ff;
   // stage 5: partial products, overflow
   logic [CM_LO_W-1:0]       a0;
   logic [CM_HI_W-1:0]       a1;
   logic [D2_C_W-1:0]        c0, c1, c2;
   logic [NUM_W-1:0]         num5, num7;
   logic [PPLL_W-1:0]        pp_ll_ff;
   logic [PPHL_W-1:0]        pp_hl_ff;
   logic [PPHH_W-1:0]        pp_hh_ff;
   logic [TPROD_W-1:0]       tp0_ff, tp1_ff, tp2_ff;
   logic [CM_W-1:0]          cm5_ff;
   logic                     neg5_ff, ovf5_ff, ovf5_in;
   logic [ST_W-1:0]          st5_ff;
   logic [D2_W-1:0]          d2_5_ff;
   // stage 6: sums for the straight-line test
   logic [SQ_W-1:0]          lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [CM_W-1:0]          cm6_ff;
   logic                     neg6_ff, ovf6_ff;
   logic [ST_W-1:0]          st6_ff;
   logic [D2_W-1:0]          d2_6_ff;
   // stage 7: first divider entry
   tac_div_type              out_ff, out_in;

   always_comb begin
      adv[NSTG] = out_ready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         adv[i] = !v_ff[i] || adv[i+1];
      end
   end

   assign v_in = {v_ff[NSTG-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) v_ff[i] <= v_in[i];
         end
      end
   end

   assign req_if.ready = adv[0];
   assign out_valid    = v_ff[NSTG-1];
   assign out_data     = out_ff;

   // stage 1
   assign dx_in = {req_if.goal_x[POS_W-1], req_if.goal_x}
                - {req_if.start_x[POS_W-1], req_if.start_x};
   assign dy_in = {req_if.goal_y[POS_W-1], req_if.goal_y}
                - {req_if.start_y[POS_W-1], req_if.start_y};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         hx_ff <= req_if.heading_x;
         hy_ff <= req_if.heading_y;
      end
   end

   // stage 2
   assign pxy_in   = PROD_W'(dx_ff) * PROD_W'(hy_ff);
   assign pyx_in   = PROD_W'(dy_ff) * PROD_W'(hx_ff);
   assign pxx_in   = PROD_W'(dx_ff) * PROD_W'(hx_ff);
   assign pyy_in   = PROD_W'(dy_ff) * PROD_W'(hy_ff);
   assign sqx_full = D2_W'(dx_ff) * D2_W'(dx_ff);
   assign sqy_full = D2_W'(dy_ff) * D2_W'(dy_ff);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         pxy_ff <= pxy_in;
         pyx_ff <= pyx_in;
         pxx_ff <= pxx_in;
         pyy_ff <= pyy_in;
         sqx_ff <= sqx_full[SQ1_W-1:0];
         sqy_ff <= sqy_full[SQ1_W-1:0];
      end
   end

   // stage 3
   assign cross_in = DOT_W'(pxy_ff) - DOT_W'(pyx_ff);
   assign dot_in   = DOT_W'(pxx_ff) + DOT_W'(pyy_ff);
   assign d2_3_in  = D2_W'(sqx_ff) + D2_W'(sqy_ff);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         cross_ff <= cross_in;
         dot_ff   <= dot_in;
         d2_3_ff  <= d2_3_in;
      end
   end

   // stage 4: reached wins over not-ahead
   assign cross_neg = -cross_ff;
   assign cm4_in    = cross_ff[DOT_W-1] ? cross_neg[CM_W-1:0] : cross_ff[CM_W-1:0];

   always_comb begin
      if (d2_3_ff < D2_W'(cfg.md_sq)) begin
         st4_in = ST_REACHED;
      end else if (dot_ff[DOT_W-1] || (dot_ff == '0)) begin
         st4_in = ST_BEHIND;
      end else begin
         st4_in = ST_ARC;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         cm4_ff  <= cm4_in;
         neg4_ff <= cross_ff[DOT_W-1];
         st4_ff  <= st4_in;
         d2_4_ff <= d2_3_ff;
      end
   end

   // stage 5
   assign a0   = cm4_ff[CM_LO_W-1:0];
   assign a1   = cm4_ff[CM_W-1:CM_LO_W];
   assign c0   = d2_4_ff[D2_C_W-1:0];
   assign c1   = d2_4_ff[2*D2_C_W-1:D2_C_W];
   assign c2   = d2_4_ff[3*D2_C_W-1:2*D2_C_W];
   assign num5 = {cm4_ff, {DIV_SHIFT{1'b0}}};
   // quotient would not fit below the saturation point
   assign ovf5_in = D2_W'(num5[NUM_W-1:QUO_W]) >= d2_4_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         pp_ll_ff <= PPLL_W'(a0) * PPLL_W'(a0);
         pp_hl_ff <= PPHL_W'(a1) * PPHL_W'(a0);
         pp_hh_ff <= PPHH_W'(a1) * PPHH_W'(a1);
         tp0_ff   <= TPROD_W'(cfg.t2) * TPROD_W'(c0);
         tp1_ff   <= TPROD_W'(cfg.t2) * TPROD_W'(c1);
         tp2_ff   <= TPROD_W'(cfg.t2) * TPROD_W'(c2);
         cm5_ff   <= cm4_ff;
         neg5_ff  <= neg4_ff;
         ovf5_ff  <= ovf5_in;
         st5_ff   <= st4_ff;
         d2_5_ff  <= d2_4_ff;
      end
   end

   // stage 6: cross^2 and t2 * d2 reassembled
   assign lhs_in = (SQ_W'(pp_hh_ff) << (2 * CM_LO_W))
                 + (SQ_W'(pp_hl_ff) << (CM_LO_W + 1))
                 + SQ_W'(pp_ll_ff);
   assign rhs_in = (SQ_W'(tp2_ff) << (2 * D2_C_W))
                 + (SQ_W'(tp1_ff) << D2_C_W)
                 + SQ_W'(tp0_ff);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         lhs_ff  <= lhs_in;
         rhs_ff  <= rhs_in;
         cm6_ff  <= cm5_ff;
         neg6_ff <= neg5_ff;
         ovf6_ff <= ovf5_ff;
         st6_ff  <= st5_ff;
         d2_6_ff <= d2_5_ff;
      end
   end

   // stage 7
   assign num7 = {cm6_ff, {DIV_SHIFT{1'b0}}};

   always_comb begin
      out_in.rem    = D2_W'(num7[NUM_W-1:QUO_W]);
      out_in.den    = d2_6_ff;
      out_in.num_lo = num7[QUO_W-1:0];
      out_in.quo    = '0;
      out_in.status = st6_ff;
      out_in.zero   = lhs_ff < rhs_ff;
      out_in.neg    = neg6_ff;
      out_in.ovf    = ovf6_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) out_ff <= out_in;
   end

endmodule

>>> rtl/tac_div_cell.sv
module tac_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tac_pkg::tac_div_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tac_pkg::tac_div_type out_data
);
   import tac_pkg::*;

   logic            v_ff;
   logic            adv;
   logic [D2_W:0]   shifted, den_x, diff;
   logic            ge;
   tac_div_type     d_ff, d_in;

   assign adv      = !v_ff || out_ready;
   assign in_ready = adv;

   // one restoring step: bring in the next numerator bit, subtract if it fits
   assign shifted = {in_data.rem, in_data.num_lo[QUO_W-1]};
   assign den_x   = {1'b0, in_data.den};
   assign ge      = shifted >= den_x;
   assign diff    = shifted - den_x;

   always_comb begin
      d_in        = in_data;
      d_in.rem    = ge ? diff[D2_W-1:0] : shifted[D2_W-1:0];
      d_in.num_lo = {in_data.num_lo[QUO_W-2:0], 1'b0};
      d_in.quo    = {in_data.quo[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) d_ff <= d_in;
   end

   assign out_valid = v_ff;
   assign out_data  = d_ff;

endmodule

>>> rtl/tangent_arc_curvature.sv
// Tangent arc curvature: for a start point, a Q2.14 heading and a goal point it
// returns the signed Q16.16 curvature (positive = right turn) of the arc leaving
// the start along the heading and passing through the goal, or a status of goal
// reached / goal not ahead. One request is taken every clock while not stalled;
// a request passes through seven arithmetic stages (offset, products, sums,
// checks, partial products, reassembly, divider load), a chain
// of 31 divider cells that each settle one quotient bit with a 67-bit compare
// and subtract, and the output register. A stalled result holds the chain stage
// by stage, so empty stages keep filling and requests are still taken until the
// whole chain is occupied. min_distance sits at byte address 0 and
// min_turn_sine at 4; write them only while no request is in flight.
module tangent_arc_curvature (
   input  logic                        clock,
   input  logic                        reset,
   tac_req_if.sink                     req_if,
   tac_rsp_if.source                   rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tac_pkg::CSR_AW-1:0]  paddr,
   input  logic [tac_pkg::CSR_DW-1:0]  pwdata,
   output logic [tac_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import tac_pkg::*;

   tac_cfg_type              cfg;
   logic [QUO_W:0]           cell_v;
   logic [QUO_W:0]           cell_r;
   tac_div_type              cell_d [0:QUO_W];
   tac_div_type              last;
   logic                     rsp_v_ff, rsp_adv;
   logic [ST_W-1:0]          st_ff;
   logic signed [CURV_W-1:0] curv_ff, curv_in, mag, mag_neg;

   tac_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_if    (req_if),
      .out_valid (cell_v[0]),
      .out_ready (cell_r[0]),
      .out_data  (cell_d[0])
   );

   for (genvar k = 0; k < QUO_W; k++) begin : g_cell
      tac_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_v[k]),
         .in_ready  (cell_r[k]),
         .in_data   (cell_d[k]),
         .out_valid (cell_v[k+1]),
         .out_ready (cell_r[k+1]),
         .out_data  (cell_d[k+1])
      );
   end

   assign last    = cell_d[QUO_W];
   assign rsp_adv = !rsp_v_ff || rsp_if.ready;
   assign cell_r[QUO_W] = rsp_adv;

   assign mag     = {1'b0, last.quo};
   assign mag_neg = -mag;

   always_comb begin
      if ((last.status != ST_ARC) || last.zero) begin
         curv_in = '0;
      end else if (last.ovf) begin
         curv_in = last.neg ? CURV_MIN : CURV_MAX;
      end else begin
         curv_in = last.neg ? mag_neg : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (rsp_adv) begin
         rsp_v_ff <= cell_v[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_adv) begin
         st_ff   <= last.status;
         curv_ff <= curv_in;
      end
   end

   assign rsp_if.valid         = rsp_v_ff;
   assign rsp_if.status        = st_ff;
   assign rsp_if.arc_curvature = curv_ff;

`ifndef SYNTHESIS
   a_chain_hold: assert property (@(posedge clock) disable iff (reset)
      (cell_v[QUO_W] && !cell_r[QUO_W]) |=> cell_v[QUO_W])
      else $error("divider entry lost while output stalled");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(cell_v[QUO_W]))
      else $error("result appeared without a divider entry");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (cell_v[QUO_W] && cell_r[QUO_W] && (last.status != ST_ARC))
      |=> (rsp_if.arc_curvature == '0))
      else $error("curvature not zero on failed request");
`endif

endmodule

>>> tb/tb_tangent_arc_curvature.sv
`timescale 1ns / 1ps

module tb_tangent_arc_curvature;
   import tac_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int BATCHES     = 7;
   localparam int BATCH_ITEMS = 100;
   localparam int SHIFT       = 2 * FRAC_BITS - 13;

   typedef struct packed {
      logic [POS_W-1:0]  start_x;
      logic [POS_W-1:0]  start_y;
      logic [HEAD_W-1:0] heading_x;
      logic [HEAD_W-1:0] heading_y;
      logic [POS_W-1:0]  goal_x;
      logic [POS_W-1:0]  goal_y;
   } arc_query_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [CURV_W-1:0] curv;
   } arc_result_type;

   typedef struct {
      logic [31:0]    md;
      logic [31:0]    ts;
      arc_query_type  query;
      bit             typed;
      arc_result_type result;
   } arc_row_type;

   logic clock;
   logic reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;

   tac_req_if req_if ();
   tac_rsp_if rsp_if ();

   tangent_arc_curvature i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic [MD_W-1:0] cfg_min_distance  = MIN_DISTANCE_RST;
   logic [TS_W-1:0] cfg_min_turn_sine = MIN_TURN_SINE_RST;

   arc_result_type arc_expected_q[$];
   arc_row_type    directed_rows[$];
   int             mismatch_count  = 0;
   int             cycle_count     = 0;
   int             send_idle_pct   = 37;
   int             recv_idle_pct   = 55;
   int             hold_off_cycles = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
   endtask

   // curvature of the tangent arc through the goal, from the local register copies
   function automatic arc_result_type predict_arc(input arc_query_type q);
      longint         dx, dy, hx, hy, cross_v, dot;
      logic [127:0]   cm, adx, ady, d2, md2, thr, quo;
      arc_result_type r;
      dx      = longint'($signed(q.goal_x)) - longint'($signed(q.start_x));
      dy      = longint'($signed(q.goal_y)) - longint'($signed(q.start_y));
      hx      = longint'($signed(q.heading_x));
      hy      = longint'($signed(q.heading_y));
      cross_v = dx * hy - dy * hx;
      dot     = dx * hx + dy * hy;
      cm      = (cross_v < 0) ? 128'(-cross_v) : 128'(cross_v);
      adx     = (dx < 0) ? 128'(-dx) : 128'(dx);
      ady     = (dy < 0) ? 128'(-dy) : 128'(dy);
      d2      = adx * adx + ady * ady;
      md2     = 128'(cfg_min_distance) * 128'(cfg_min_distance);
      thr     = 128'(cfg_min_turn_sine) * 128'(cfg_min_turn_sine) * d2;
      r.status = ST_ARC;
      r.curv   = '0;
      if (d2 < md2) begin
         r.status = ST_REACHED;
      end else if (dot <= 0) begin
         r.status = ST_BEHIND;
      end else if (cm * cm >= thr) begin
         quo = (cm << SHIFT) / d2;
         if (cross_v >= 0)
            r.curv = (quo > 128'h7FFF_FFFF) ? CURV_MAX : quo[31:0];
         else
            r.curv = (quo >= 128'h8000_0000) ? CURV_MIN : -$signed(quo[31:0]);
      end
      return r;
   endfunction

   function automatic arc_query_type random_query();
      arc_query_type q;
      int            kind;
      int            k;
      int            j;
      real           ang;
      longint        hx, hy, along, lateral, dx, dy, span;
      longint        ext[5] = '{-32768, -16384, 0, 16384, 32767};
      kind      = $urandom_range(99);
      q.start_x = $urandom;
      q.start_y = $urandom;
      q.heading_x = HEAD_W'($urandom);
      q.heading_y = HEAD_W'($urandom);
      q.goal_x  = $urandom;
      q.goal_y  = $urandom;
      if (kind >= 15) begin
         if (kind < 25) begin
            hx = ext[$urandom_range(4)];
            hy = ext[$urandom_range(4)];
         end else begin
            ang = $urandom_range(62831) / 10000.0;
            hx  = $rtoi($cos(ang) * 16384.0);
            hy  = $rtoi($sin(ang) * 16384.0);
         end
         if (kind < 40) begin
            // around the goal-reached radius
            span = longint'(cfg_min_distance) + 2;
            dx   = longint'($urandom_range(0, 2 * span)) - span;
            dy   = longint'($urandom_range(0, 2 * span)) - span;
         end else begin
            k       = $urandom_range(24);
            j       = $urandom_range(k);
            span    = 64'sd1 << k;
            along   = longint'($urandom_range(0, span));
            lateral = longint'($urandom_range(0, 2 * (64'sd1 << j))) - (64'sd1 << j);
            if ($urandom_range(9) == 0) along = -along;
            dx = (along * hx - lateral * hy) >>> 14;
            dy = (along * hy + lateral * hx) >>> 14;
         end
         q.heading_x = hx[15:0];
         q.heading_y = hy[15:0];
         q.goal_x    = q.start_x + dx[31:0];
         q.goal_y    = q.start_y + dy[31:0];
      end
      return q;
   endfunction

   task automatic add_row(input logic [31:0] md, input logic [31:0] ts,
                          input logic [31:0] sx, input logic [31:0] sy,
                          input logic [31:0] hx, input logic [31:0] hy,
                          input logic [31:0] gx, input logic [31:0] gy,
                          input bit typed, input logic [ST_W-1:0] st,
                          input logic [31:0] curv);
      arc_row_type row;
      row.md    = md;
      row.ts    = ts;
      row.query = '{sx, sy, hx[15:0], hy[15:0], gx, gy};
      row.typed = typed;
      row.result = '{st, curv};
      directed_rows.push_back(row);
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_query(input arc_query_type q, input bit typed,
                             input arc_result_type typed_result);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.start_x   <= q.start_x;
      req_if.start_y   <= q.start_y;
      req_if.heading_x <= q.heading_x;
      req_if.heading_y <= q.heading_y;
      req_if.goal_x    <= q.goal_x;
      req_if.goal_y    <= q.goal_y;
      do @(posedge clock); while (!req_if.ready);
      arc_expected_q.push_back(typed ? typed_result : predict_arc(q));
      @(negedge clock);
   endtask

   task automatic await_results();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (arc_expected_q.size() != 0) @(negedge clock);
   endtask

   // write then read back one register
   task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      logic [31:0] masked;
      masked = (idx == REG_MIN_DISTANCE) ? {16'd0, value[MD_W-1:0]}
                                         : {17'd0, value[TS_W-1:0]};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_MIN_DISTANCE) cfg_min_distance = value[MD_W-1:0];
      else cfg_min_turn_sine = value[TS_W-1:0];
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== masked) note_mismatch("register readback", masked, prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      arc_result_type exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (arc_expected_q.size() == 0) begin
            note_mismatch("result with no request", '0, rsp_if.arc_curvature);
         end else begin
            exp_r = arc_expected_q.pop_front();
            if (rsp_if.status !== exp_r.status)
               note_mismatch("status", exp_r.status, rsp_if.status);
            if (rsp_if.arc_curvature !== exp_r.curv)
               note_mismatch("arc_curvature", exp_r.curv, rsp_if.arc_curvature);
         end
      end
   end

   initial begin
      arc_row_type   row;
      arc_query_type q;
      int            b;
      int            n;
      logic [31:0]   md_set [BATCHES];
      logic [31:0]   ts_set [BATCHES];

      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_if.valid     = 1'b0;
      req_if.start_x   = '0;
      req_if.start_y   = '0;
      req_if.heading_x = '0;
      req_if.heading_y = '0;
      req_if.goal_x    = '0;
      req_if.goal_y    = '0;

      // directed requests; rows with typed results need no predictor
      add_row(7, 16, 0, 0, 16384, 0, 0, 0, 1, ST_REACHED, 0);
      add_row(7, 16, 0, 0, 16384, 0, 6, 0, 1, ST_REACHED, 0);
      add_row(7, 16, 0, 0, 16384, 0, 7, 0, 1, ST_ARC, 0);
      add_row(7, 16, 0, 0, 16384, 0, -65536, 0, 1, ST_BEHIND, 0);
      add_row(7, 16, 0, 0, 16384, 0, 0, 65536, 1, ST_BEHIND, 0);
      add_row(7, 16, 0, 0, 0, 0, 65536, 0, 1, ST_BEHIND, 0);
      add_row(7, 16, 0, 0, 16384, 0, 65536, -65536, 1, ST_ARC, 65536);
      add_row(7, 16, 0, 0, 16384, 0, 65536, 65536, 1, ST_ARC, -65536);
      add_row(7, 16, 0, 0, 16384, 0, 655360, 1, 1, ST_ARC, 0);
      add_row(7, 16, 0, 0, 1, -32768, 7, 0, 1, ST_ARC, CURV_MIN);
      add_row(7, 16, 0, 0, 1, 32767, 7, 0, 1, ST_ARC, CURV_MAX);
      add_row(7, 16, 32'h8000_0000, 32'h8000_0000, 16384, 0,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, ST_ARC, 0);
      add_row(7, 16, 32'h7FFF_FFFF, 32'h8000_0000, -16384, 16384,
              32'h8000_0000, 32'h7FFF_FFFF, 0, ST_ARC, 0);
      add_row(7, 16, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -32768, -32768,
              32'h8000_0000, 32'h8000_0000, 0, ST_ARC, 0);
      add_row(7, 16, 0, 0, 16384, 0, 32'h7FFF_FFFF, 1, 0, ST_ARC, 0);
      add_row(7, 16, 100000, 100000, 0, -16384, 400000, 0, 0, ST_ARC, 0);
      add_row(7, 16, -5, 9, 11585, 11585, 70000, 80000, 0, ST_ARC, 0);
      // zero offset with no reach radius falls to not-ahead
      add_row(0, 0, 12345, -678, 16384, 0, 12345, -678, 1, ST_BEHIND, 0);
      add_row(0, 0, 0, 0, 1, 32767, 1, 0, 1, ST_ARC, CURV_MAX);
      add_row(0, 0, 0, 0, 16384, 0, 1, 0, 1, ST_ARC, 0);
      add_row(65535, 16384, 0, 0, 16384, 0, 65534, 0, 1, ST_REACHED, 0);
      add_row(65535, 16384, 0, 0, 16384, 0, 65535, 0, 1, ST_ARC, 0);
      add_row(65535, 16384, 0, 0, 0, 16384, 65536, 65536, 0, ST_ARC, 0);

      md_set = '{7, 0, 65535, 32'hFFFF_FFFF, $urandom_range(0, 64), $urandom, 0};
      ts_set = '{16, 0, 16384, 32'hFFFF_FFFF, $urandom_range(0, 16384), $urandom, 16384};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.md[MD_W-1:0] != cfg_min_distance || row.ts[TS_W-1:0] != cfg_min_turn_sine) begin
            await_results();
            write_register(REG_MIN_DISTANCE, row.md);
            write_register(REG_MIN_TURN_SINE, row.ts);
         end
         send_query(row.query, row.typed, row.result);
      end

      for (b = 0; b < BATCHES; b++) begin
         if (b < 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 55;
         end else if (b < 5) begin
            send_idle_pct = 55;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         await_results();
         write_register(REG_MIN_DISTANCE, md_set[b]);
         write_register(REG_MIN_TURN_SINE, ts_set[b]);
         for (n = 0; n < BATCH_ITEMS; n++) begin
            // long back-pressure: the pipeline fills and stalls the request side
            if (b == 1 && n == 40) hold_off_cycles = 400;
            if (b == 2 && n == 50) await_results();
            q = random_query();
            send_query(q, 1'b0, '0);
         end
      end

      await_results();
      repeat (60) @(negedge clock);
      if (mismatch_count == 0 && arc_expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
